FILE: design/sac_pkg.sv
package sac_pkg;

  localparam int unsigned MAX_CLASSES_DEF = 16;
  localparam int unsigned EXP_DEPTH_DEF   = 256;
  localparam int unsigned RESULT_LIMIT    = 16;

  localparam int unsigned LOGIT_W   = 16;
  localparam int unsigned LABEL_W   = 4;
  localparam int unsigned TAG_W     = 16;
  localparam int unsigned PROB_W    = 16;
  localparam int unsigned EXP_W     = 17;
  localparam int unsigned JOB_CNT_W = 7;

  // exp(d) is zero below -16.0; table index = (-d * depth) >> 12
  localparam int unsigned EXP_SHIFT = 12;
  localparam int unsigned MAG_W     = 13;
  localparam logic signed [LOGIT_W:0] EXP_DIFF_MIN = -17'sd4096;

  // probability divider: (e << 16) + sum/2 over sum, 17 quotient bits
  localparam int unsigned DIV_NUM_W = 34;
  localparam int unsigned DIV_Q_W   = 17;

  localparam logic signed [LOGIT_W-1:0] LOGIT_MIN = 16'sh8000;
  localparam logic [PROB_W-1:0]         PROB_MAX  = 16'hFFFF;

  typedef struct packed {
    logic                      bank;
    logic [JOB_CNT_W-1:0]      n;
    logic signed [LOGIT_W-1:0] peak;
    logic [LABEL_W-1:0]        label;
    logic [TAG_W-1:0]          tag;
    logic                      dropped;
  } sac_job_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_EXP_RD,
    BK_EXP_IDX,
    BK_EXP_WR,
    BK_DIV_RD,
    BK_DIV_LOAD,
    BK_DIV_RUN,
    BK_DIV_WR,
    BK_EMIT_RD,
    BK_EMIT_WAIT
  } sac_bk_state_t;

  // Q0.32 product, truncated
  function automatic logic [63:0] mul_q32(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[95:32];
  endfunction

  // table entry idx: r^idx in Q0.32, rounded to Q1.16
  function automatic logic [EXP_W-1:0] exp_entry(input int unsigned idx,
                                                 input logic [63:0] r);
    logic [63:0] v;
    v = 64'h1_0000_0000;
    for (int unsigned k = 0; k < idx; k++) begin
      v = mul_q32(v, r);
    end
    return EXP_W'((v + 64'd32768) >> 16);
  endfunction

endpackage

FILE: design/sac_if.sv
interface sac_in_if;
  import sac_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [LOGIT_W-1:0] logit;
  logic                      last_logit;
  logic [LABEL_W-1:0]        true_label;
  logic [TAG_W-1:0]          sample_tag;

  modport source(output valid, logit, last_logit, true_label, sample_tag, input ready);
  modport sink(input valid, logit, last_logit, true_label, sample_tag, output ready);
endinterface

interface sac_out_if;
  import sac_pkg::*;
  logic               valid;
  logic               ready;
  logic [3:0]         class_index;
  logic [PROB_W-1:0]  probability;
  logic [3:0]         predicted_class;
  logic [PROB_W-1:0]  confidence;
  logic               label_match;
  logic [TAG_W-1:0]   tag_out;
  logic               overflow_flag;
  logic               last_result;

  modport source(output valid, class_index, probability, predicted_class, confidence,
                 label_match, tag_out, overflow_flag, last_result, input ready);
  modport sink(input valid, class_index, probability, predicted_class, confidence,
               label_match, tag_out, overflow_flag, last_result, output ready);
endinterface

FILE: design/sac_ram.sv
module sac_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AddrW-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: design/sac_front.sv
module sac_front #(
  parameter int unsigned MAX_CLASSES = sac_pkg::MAX_CLASSES_DEF,
  localparam int unsigned ClsW = $clog2(MAX_CLASSES),
  localparam int unsigned CntW = $clog2(MAX_CLASSES + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  sac_in_if.sink                        in_chan,
  input  logic                          q_full,
  output logic                          job_push,
  output sac_pkg::sac_job_t             push_job,
  output logic                          lram_we,
  output logic [ClsW:0]                 lram_waddr,
  output logic [sac_pkg::LOGIT_W-1:0]   lram_wdata
);
  import sac_pkg::*;

  logic [CntW-1:0]           count_r, count_nxt, count_upd;
  logic signed [LOGIT_W-1:0] peak_r, peak_nxt, peak_upd;
  logic                      dropped_r, dropped_nxt, dropped_upd;
  logic                      bank_r, bank_nxt;
  logic                      accept, room, take;

  assign in_chan.ready = !q_full;
  assign accept        = in_chan.valid && in_chan.ready;
  assign room          = count_r < CntW'(MAX_CLASSES);
  assign take          = accept && room;

  always_comb begin
    count_upd   = take ? count_r + CntW'(1) : count_r;
    peak_upd    = (take && (in_chan.logit > peak_r)) ? in_chan.logit : peak_r;
    dropped_upd = dropped_r | (accept && !room);

    job_push         = accept && in_chan.last_logit;
    push_job.bank    = bank_r;
    push_job.n       = JOB_CNT_W'(count_upd);
    push_job.peak    = peak_upd;
    push_job.label   = in_chan.true_label;
    push_job.tag     = in_chan.sample_tag;
    push_job.dropped = dropped_upd;

    // close the sample and switch to the other bank
    if (job_push) begin
      count_nxt   = '0;
      peak_nxt    = LOGIT_MIN;
      dropped_nxt = 1'b0;
      bank_nxt    = ~bank_r;
    end else begin
      count_nxt   = count_upd;
      peak_nxt    = peak_upd;
      dropped_nxt = dropped_upd;
      bank_nxt    = bank_r;
    end
  end

  assign lram_we    = take;
  assign lram_waddr = {bank_r, count_r[ClsW-1:0]};
  assign lram_wdata = LOGIT_W'(in_chan.logit);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      peak_r    <= LOGIT_MIN;
      dropped_r <= 1'b0;
      bank_r    <= 1'b0;
    end else begin
      count_r   <= count_nxt;
      peak_r    <= peak_nxt;
      dropped_r <= dropped_nxt;
      bank_r    <= bank_nxt;
    end
  end

endmodule

FILE: design/sac_jobq.sv
module sac_jobq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  sac_pkg::sac_job_t push_job,
  input  logic              pop,
  output logic              head_valid,
  output sac_pkg::sac_job_t head_job,
  output logic              full
);
  import sac_pkg::*;

  sac_job_t   q_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r, cnt_nxt;

  always_comb begin
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 2'd1;
      2'b01:   cnt_nxt = cnt_r - 2'd1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  assign head_valid = cnt_r != 2'd0;
  assign full       = cnt_r == 2'd2;
  assign head_job   = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

FILE: design/sac_back.sv
module sac_back #(
  parameter int unsigned MAX_CLASSES     = sac_pkg::MAX_CLASSES_DEF,
  parameter int unsigned EXP_TABLE_DEPTH = sac_pkg::EXP_DEPTH_DEF,
  localparam int unsigned ClsW = $clog2(MAX_CLASSES)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_valid,
  input  sac_pkg::sac_job_t           q_job,
  output logic                        q_pop,
  output logic                        lram_re,
  output logic [ClsW:0]               lram_raddr,
  input  logic [sac_pkg::LOGIT_W-1:0] lram_rdata,
  output logic                        eram_we,
  output logic [ClsW-1:0]             eram_waddr,
  output logic [sac_pkg::EXP_W-1:0]   eram_wdata,
  output logic                        eram_re,
  output logic [ClsW-1:0]             eram_raddr,
  input  logic [sac_pkg::EXP_W-1:0]   eram_rdata,
  sac_out_if.source                   out_chan
);
  import sac_pkg::*;

  localparam int unsigned CntW     = $clog2(MAX_CLASSES + 1);
  localparam int unsigned EmW      = (CntW > 5) ? CntW : 5;
  localparam int unsigned LblW     = (ClsW > LABEL_W) ? ClsW : LABEL_W;
  localparam int unsigned SumW     = $clog2(MAX_CLASSES * (2 ** 16) + 1);
  localparam int unsigned RemW     = SumW + 1;
  localparam int unsigned StepW    = $clog2(DIV_Q_W);
  localparam int unsigned ExpIdxW  = $clog2(EXP_TABLE_DEPTH);
  localparam int unsigned ProdW    = MAG_W + $clog2(EXP_TABLE_DEPTH + 1);
  localparam int unsigned IdxFullW = ProdW - EXP_SHIFT;

  // per-step ratio r = exp(-16/depth) by a series through the 12th power in Q0.32
  localparam logic [63:0] ExpOne = 64'h1_0000_0000;
  localparam logic [63:0] ExpH   = (64'd16 << 32) / 64'(EXP_TABLE_DEPTH);
  localparam logic [63:0] ExpT1  = mul_q32(ExpOne, ExpH) / 64'd1;
  localparam logic [63:0] ExpT2  = mul_q32(ExpT1, ExpH) / 64'd2;
  localparam logic [63:0] ExpT3  = mul_q32(ExpT2, ExpH) / 64'd3;
  localparam logic [63:0] ExpT4  = mul_q32(ExpT3, ExpH) / 64'd4;
  localparam logic [63:0] ExpT5  = mul_q32(ExpT4, ExpH) / 64'd5;
  localparam logic [63:0] ExpT6  = mul_q32(ExpT5, ExpH) / 64'd6;
  localparam logic [63:0] ExpT7  = mul_q32(ExpT6, ExpH) / 64'd7;
  localparam logic [63:0] ExpT8  = mul_q32(ExpT7, ExpH) / 64'd8;
  localparam logic [63:0] ExpT9  = mul_q32(ExpT8, ExpH) / 64'd9;
  localparam logic [63:0] ExpT10 = mul_q32(ExpT9, ExpH) / 64'd10;
  localparam logic [63:0] ExpT11 = mul_q32(ExpT10, ExpH) / 64'd11;
  localparam logic [63:0] ExpT12 = mul_q32(ExpT11, ExpH) / 64'd12;
  localparam logic [63:0] ExpR   = ExpOne - ExpT1 + ExpT2 - ExpT3 + ExpT4 - ExpT5 + ExpT6
                                 - ExpT7 + ExpT8 - ExpT9 + ExpT10 - ExpT11 + ExpT12;

  logic [EXP_W-1:0] exp_rom [EXP_TABLE_DEPTH];

  for (genvar g = 0; g < EXP_TABLE_DEPTH; g++) begin : g_rom
    assign exp_rom[g] = exp_entry(g, ExpR);
  end

  sac_bk_state_t st_r, st_nxt;

  logic [CntW-1:0]    elem_r, elem_nxt;
  logic [ExpIdxW-1:0] idx_r, idx_nxt;
  logic               zero_r, zero_nxt;
  logic [SumW-1:0]    sum_r, sum_nxt;
  logic [RemW-1:0]    rem_r, rem_nxt;
  logic [DIV_Q_W-1:0] low_r, low_nxt;
  logic [DIV_Q_W-1:0] quo_r, quo_nxt;
  logic [StepW-1:0]   step_r, step_nxt;
  logic [ClsW-1:0]    best_r, best_nxt;
  logic [PROB_W-1:0]  conf_r, conf_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [3:0]         out_cls_r, out_cls_nxt;
  logic [PROB_W-1:0]  out_prob_r, out_prob_nxt;
  logic [3:0]         out_pred_r, out_pred_nxt;
  logic [PROB_W-1:0]  out_conf_r, out_conf_nxt;
  logic               out_match_r, out_match_nxt;
  logic [TAG_W-1:0]   out_tag_r, out_tag_nxt;
  logic               out_ovf_r, out_ovf_nxt;
  logic               out_last_r, out_last_nxt;

  logic [CntW-1:0]      elem_inc, n_c;
  logic [EmW-1:0]       emit_n;
  logic                 elem_last, emit_last, out_free, out_load;
  logic [LOGIT_W:0]     diff;
  logic                 too_far, clamp;
  logic [MAG_W-1:0]     mag;
  logic [ProdW-1:0]     prod;
  logic [IdxFullW-1:0]  idx_full;
  logic [EXP_W-1:0]     exp_val;
  logic [DIV_NUM_W-1:0] num;
  logic [RemW-1:0]      rem_sh;
  logic                 q_bit;
  logic [PROB_W-1:0]    prob_sat;

  assign n_c       = CntW'(q_job.n);
  assign elem_inc  = elem_r + CntW'(1);
  assign elem_last = elem_inc == n_c;
  assign emit_n    = (EmW'(n_c) > EmW'(RESULT_LIMIT)) ? EmW'(RESULT_LIMIT) : EmW'(n_c);
  assign emit_last = EmW'(elem_inc) == emit_n;
  assign out_free  = !out_valid_r || out_chan.ready;

  // exp index from logit minus peak (never positive)
  assign diff     = {lram_rdata[LOGIT_W-1], lram_rdata} - {q_job.peak[LOGIT_W-1], q_job.peak};
  assign too_far  = $signed(diff) < EXP_DIFF_MIN;
  assign mag      = MAG_W'(-diff);
  assign prod     = ProdW'(mag) * ProdW'(EXP_TABLE_DEPTH);
  assign idx_full = prod[ProdW-1:EXP_SHIFT];
  assign clamp    = idx_full > IdxFullW'(EXP_TABLE_DEPTH - 1);
  assign exp_val  = zero_r ? '0 : exp_rom[idx_r];

  // restoring divider, one quotient bit per cycle
  assign num      = DIV_NUM_W'({eram_rdata, 16'd0}) + DIV_NUM_W'(sum_r >> 1);
  assign rem_sh   = {rem_r[RemW-2:0], low_r[DIV_Q_W-1]};
  assign q_bit    = rem_sh >= RemW'(sum_r);
  assign prob_sat = quo_r[DIV_Q_W-1] ? PROB_MAX : quo_r[PROB_W-1:0];

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      BK_IDLE:      if (q_valid) st_nxt = BK_EXP_RD;
      BK_EXP_RD:    st_nxt = BK_EXP_IDX;
      BK_EXP_IDX:   st_nxt = BK_EXP_WR;
      BK_EXP_WR:    st_nxt = elem_last ? BK_DIV_RD : BK_EXP_RD;
      BK_DIV_RD:    st_nxt = BK_DIV_LOAD;
      BK_DIV_LOAD:  st_nxt = BK_DIV_RUN;
      BK_DIV_RUN:   if (step_r == StepW'(DIV_Q_W - 1)) st_nxt = BK_DIV_WR;
      BK_DIV_WR:    st_nxt = elem_last ? BK_EMIT_RD : BK_DIV_RD;
      BK_EMIT_RD:   st_nxt = BK_EMIT_WAIT;
      BK_EMIT_WAIT: begin
        if (out_free) begin
          st_nxt = emit_last ? BK_IDLE : BK_EMIT_RD;
        end
      end
      default:      st_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    lram_re    = 1'b0;
    eram_we    = 1'b0;
    eram_re    = 1'b0;
    eram_wdata = exp_val;
    out_load   = 1'b0;
    q_pop      = 1'b0;
    case (st_r)
      BK_EXP_RD:  lram_re = 1'b1;
      BK_EXP_WR:  eram_we = 1'b1;
      BK_DIV_RD:  eram_re = 1'b1;
      BK_DIV_WR: begin
        eram_we    = 1'b1;
        eram_wdata = EXP_W'(prob_sat);
      end
      BK_EMIT_RD: eram_re = 1'b1;
      BK_EMIT_WAIT: begin
        out_load = out_free;
        q_pop    = out_free && emit_last;
      end
      default: ;
    endcase
  end

  assign lram_raddr = {q_job.bank, elem_r[ClsW-1:0]};
  assign eram_waddr = elem_r[ClsW-1:0];
  assign eram_raddr = elem_r[ClsW-1:0];

  always_comb begin
    elem_nxt = elem_r;
    idx_nxt  = idx_r;
    zero_nxt = zero_r;
    sum_nxt  = sum_r;
    rem_nxt  = rem_r;
    low_nxt  = low_r;
    quo_nxt  = quo_r;
    step_nxt = step_r;
    best_nxt = best_r;
    conf_nxt = conf_r;
    case (st_r)
      BK_IDLE: begin
        elem_nxt = '0;
        sum_nxt  = '0;
      end
      BK_EXP_IDX: begin
        zero_nxt = too_far;
        idx_nxt  = clamp ? ExpIdxW'(EXP_TABLE_DEPTH - 1) : idx_full[ExpIdxW-1:0];
      end
      BK_EXP_WR: begin
        sum_nxt  = sum_r + SumW'(exp_val);
        elem_nxt = elem_last ? '0 : elem_inc;
      end
      BK_DIV_LOAD: begin
        rem_nxt  = RemW'(num[DIV_NUM_W-1:DIV_Q_W]);
        low_nxt  = num[DIV_Q_W-1:0];
        step_nxt = '0;
      end
      BK_DIV_RUN: begin
        rem_nxt  = q_bit ? rem_sh - RemW'(sum_r) : rem_sh;
        low_nxt  = {low_r[DIV_Q_W-2:0], 1'b0};
        quo_nxt  = {quo_r[DIV_Q_W-2:0], q_bit};
        step_nxt = step_r + StepW'(1);
      end
      BK_DIV_WR: begin
        // strict compare keeps the lowest index on ties
        if (elem_r == '0 || prob_sat > conf_r) begin
          best_nxt = elem_r[ClsW-1:0];
          conf_nxt = prob_sat;
        end
        elem_nxt = elem_last ? '0 : elem_inc;
      end
      BK_EMIT_WAIT: begin
        if (out_free) begin
          elem_nxt = elem_inc;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_cls_nxt   = out_cls_r;
    out_prob_nxt  = out_prob_r;
    out_pred_nxt  = out_pred_r;
    out_conf_nxt  = out_conf_r;
    out_match_nxt = out_match_r;
    out_tag_nxt   = out_tag_r;
    out_ovf_nxt   = out_ovf_r;
    out_last_nxt  = out_last_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_cls_nxt   = 4'(elem_r);
      out_prob_nxt  = eram_rdata[PROB_W-1:0];
      out_pred_nxt  = 4'(best_r);
      out_conf_nxt  = conf_r;
      out_match_nxt = LblW'(best_r) == LblW'(q_job.label);
      out_tag_nxt   = q_job.tag;
      out_ovf_nxt   = q_job.dropped;
      out_last_nxt  = emit_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    elem_r      <= elem_nxt;
    idx_r       <= idx_nxt;
    zero_r      <= zero_nxt;
    sum_r       <= sum_nxt;
    rem_r       <= rem_nxt;
    low_r       <= low_nxt;
    quo_r       <= quo_nxt;
    step_r      <= step_nxt;
    best_r      <= best_nxt;
    conf_r      <= conf_nxt;
    out_cls_r   <= out_cls_nxt;
    out_prob_r  <= out_prob_nxt;
    out_pred_r  <= out_pred_nxt;
    out_conf_r  <= out_conf_nxt;
    out_match_r <= out_match_nxt;
    out_tag_r   <= out_tag_nxt;
    out_ovf_r   <= out_ovf_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_chan.valid           = out_valid_r;
  assign out_chan.class_index     = out_cls_r;
  assign out_chan.probability     = out_prob_r;
  assign out_chan.predicted_class = out_pred_r;
  assign out_chan.confidence      = out_conf_r;
  assign out_chan.label_match     = out_match_r;
  assign out_chan.tag_out         = out_tag_r;
  assign out_chan.overflow_flag   = out_ovf_r;
  assign out_chan.last_result     = out_last_r;

endmodule

FILE: design/softmax_argmax_classifier_head.sv
// Softmax classifier head with argmax.
// in_chan carries one signed Q8.8 logit per transfer; last_logit closes the
// sample and brings the true label and sample tag along. out_chan then
// delivers one transfer per class (at most 16), each with the Q0.16
// probability plus the sample's argmax class, confidence, label match, tag
// and drop flag; last_result marks the final one. Logits past MAX_CLASSES
// are dropped and reported through overflow_flag.
// The front takes one logit per cycle, while in_chan.ready is high, into
// one of two logit banks, so the next sample loads while the back works on
// the current one. For each class the back does an exp lookup and sum,
// then runs each class through the 17-step bit-serial divider, then emits
// one result per class; the divider sets the sustained rate.
// in_chan.ready drops once two closed samples are queued, counting the one
// the back is working on.
// Reset (rst_n low, synchronous) empties the sample queue and the output
// register; the logit and exp stores are not cleared. A stalled receiver
// holds the result in the output register and the back waits behind it.
module softmax_argmax_classifier_head #(
  parameter int unsigned MAX_CLASSES     = sac_pkg::MAX_CLASSES_DEF,
  parameter int unsigned EXP_TABLE_DEPTH = sac_pkg::EXP_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  sac_in_if.sink    in_chan,
  sac_out_if.source out_chan
);
  import sac_pkg::*;

  localparam int unsigned ClsW = $clog2(MAX_CLASSES);

  logic               lram_we, lram_re;
  logic [ClsW:0]      lram_waddr, lram_raddr;
  logic [LOGIT_W-1:0] lram_wdata, lram_rdata;
  logic               eram_we, eram_re;
  logic [ClsW-1:0]    eram_waddr, eram_raddr;
  logic [EXP_W-1:0]   eram_wdata, eram_rdata;
  logic               job_push, q_full, q_valid, q_pop;
  sac_job_t           push_job, q_job;

  sac_front #(
    .MAX_CLASSES(MAX_CLASSES)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .q_full     (q_full),
    .job_push   (job_push),
    .push_job   (push_job),
    .lram_we    (lram_we),
    .lram_waddr (lram_waddr),
    .lram_wdata (lram_wdata)
  );

  sac_jobq u_jobq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (job_push),
    .push_job   (push_job),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_job   (q_job),
    .full       (q_full)
  );

  sac_ram #(
    .WIDTH(LOGIT_W),
    .DEPTH(2 << ClsW)
  ) u_logit_ram (
    .clk   (clk),
    .we    (lram_we),
    .waddr (lram_waddr),
    .wdata (lram_wdata),
    .re    (lram_re),
    .raddr (lram_raddr),
    .rdata (lram_rdata)
  );

  sac_ram #(
    .WIDTH(EXP_W),
    .DEPTH(MAX_CLASSES)
  ) u_exp_ram (
    .clk   (clk),
    .we    (eram_we),
    .waddr (eram_waddr),
    .wdata (eram_wdata),
    .re    (eram_re),
    .raddr (eram_raddr),
    .rdata (eram_rdata)
  );

  sac_back #(
    .MAX_CLASSES    (MAX_CLASSES),
    .EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_job      (q_job),
    .q_pop      (q_pop),
    .lram_re    (lram_re),
    .lram_raddr (lram_raddr),
    .lram_rdata (lram_rdata),
    .eram_we    (eram_we),
    .eram_waddr (eram_waddr),
    .eram_wdata (eram_wdata),
    .eram_re    (eram_re),
    .eram_raddr (eram_raddr),
    .eram_rdata (eram_rdata),
    .out_chan   (out_chan)
  );

endmodule

FILE: design/sac_chk.sv
module sac_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [3:0]  class_index,
  input logic [15:0] probability,
  input logic [3:0]  predicted_class,
  input logic [15:0] confidence,
  input logic [15:0] tag_out,
  input logic        last_result
);

  logic        mid_r;
  logic [3:0]  prev_idx_r, prev_pred_r;
  logic [15:0] prev_tag_r;

  // track the previous transfer of an unfinished sample
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_r <= 1'b0;
    end else if (out_valid && out_ready) begin
      mid_r <= !last_result;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && out_ready) begin
      prev_idx_r  <= class_index;
      prev_pred_r <= predicted_class;
      prev_tag_r  <= tag_out;
    end
  end

  a_reset_clears_valid: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_conf_is_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> confidence >= probability)
    else $error("confidence below a class probability");

  a_sample_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && mid_r |-> predicted_class == prev_pred_r && tag_out == prev_tag_r
                           && class_index == prev_idx_r + 4'd1)
    else $error("results of one sample disagree");

endmodule

bind softmax_argmax_classifier_head sac_chk u_sac_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_chan.valid),
  .out_ready       (out_chan.ready),
  .class_index     (out_chan.class_index),
  .probability     (out_chan.probability),
  .predicted_class (out_chan.predicted_class),
  .confidence      (out_chan.confidence),
  .tag_out         (out_chan.tag_out),
  .last_result     (out_chan.last_result)
);

FILE: tb/testbench.sv
module testbench;
  import sac_pkg::*;

  typedef struct packed {
    logic [3:0]        cls;
    logic [PROB_W-1:0] prob;
    logic [3:0]        pred;
    logic [PROB_W-1:0] conf;
    logic              match;
    logic [TAG_W-1:0]  tag;
    logic              ovf;
    logic              tail;
  } class_result_t;

  typedef struct {
    logic signed [LOGIT_W-1:0] logit;
    logic                      last;
    logic [LABEL_W-1:0]        label;
    logic [TAG_W-1:0]          tag;
    logic                      pin;
    logic [3:0]                pred;
    logic [PROB_W-1:0]         conf;
    logic                      match;
    logic                      ovf;
  } logit_row_t;

  logic clk;
  logic rst_n;

  sac_in_if  in_chan ();
  sac_out_if out_chan ();

  softmax_argmax_classifier_head dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  // sample being gathered
  logic signed [LOGIT_W-1:0] held_logits [MAX_CLASSES_DEF];
  int                        held_count = 0;
  logic signed [LOGIT_W-1:0] peak = LOGIT_MIN;
  logic                      drop_seen = 1'b0;

  logic [EXP_W-1:0] exp_lut [EXP_DEPTH_DEF];
  class_result_t    prob_queue [$];

  int mismatches = 0;
  bit stall_req  = 1'b0;
  bit calm       = 1'b0;

  // pinned rows carry argmax, confidence, match and drop flag typed in
  logit_row_t directed_rows [16] = '{
    '{16'sh0000, 1'b1, 4'd0,  16'h0000, 1'b1, 4'd0, 16'hFFFF, 1'b1, 1'b0},
    '{LOGIT_MIN, 1'b1, 4'd5,  16'hFFFF, 1'b1, 4'd0, 16'hFFFF, 1'b0, 1'b0},
    '{16'sh0100, 1'b0, 4'd0,  16'h0000, 1'b0, 4'd0, 16'h0000, 1'b0, 1'b0},
    '{16'sh0100, 1'b1, 4'd0,  16'h1234, 1'b1, 4'd0, 16'h8000, 1'b1, 1'b0},
    '{16'sh7FFF, 1'b0, 4'd0,  16'h0000, 1'b0, 4'd0, 16'h0000, 1'b0, 1'b0},
    '{16'sh8000, 1'b1, 4'd1,  16'hA5A5, 1'b1, 4'd0, 16'hFFFF, 1'b0, 1'b0},
    '{16'sh8000, 1'b0, 4'd0,  16'h0000, 1'b0, 4'd0, 16'h0000, 1'b0, 1'b0},
    '{16'sh7FFF, 1'b1, 4'd1,  16'h5A5A, 1'b1, 4'd1, 16'hFFFF, 1'b1, 1'b0},
    '{16'sh0000, 1'b0, 4'd0,  16'h0000, 1'b0, 4'd0, 16'h0000, 1'b0, 1'b0},
    '{16'shF000, 1'b0, 4'd0,  16'h0000, 1'b0, 4'd0, 16'h0000, 1'b0, 1'b0},
    '{16'shEFFF, 1'b0, 4'd0,  16'h0000, 1'b0, 4'd0, 16'h0000, 1'b0, 1'b0},
    '{16'shF001, 1'b1, 4'd2,  16'h8001, 1'b0, 4'd0, 16'h0000, 1'b0, 1'b0},
    '{16'shFF00, 1'b0, 4'd0,  16'h0000, 1'b0, 4'd0, 16'h0000, 1'b0, 1'b0},
    '{16'sh0200, 1'b0, 4'd0,  16'h0000, 1'b0, 4'd0, 16'h0000, 1'b0, 1'b0},
    '{16'sh0200, 1'b0, 4'd0,  16'h0000, 1'b0, 4'd0, 16'h0000, 1'b0, 1'b0},
    '{16'sh0000, 1'b1, 4'd15, 16'h7FFE, 1'b0, 4'd0, 16'h0000, 1'b0, 1'b0}
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #15_000_000;
    $display("testbench: FAIL");
    $finish;
  end

  // Store one logit; on the closing logit queue the per-class probabilities.
  task automatic softmax_take_logit(input logic signed [LOGIT_W-1:0] logit,
                                    input logic last, input logic [LABEL_W-1:0] label,
                                    input logic [TAG_W-1:0] tag, input logic pin,
                                    input class_result_t pinned);
    int                d;
    int unsigned       idx;
    logic [EXP_W-1:0]  ex [MAX_CLASSES_DEF];
    logic [20:0]       sum;
    logic [PROB_W-1:0] pr [MAX_CLASSES_DEF];
    longint unsigned   p;
    int                best;
    logic [PROB_W-1:0] conf;
    int                emit;
    class_result_t     r;
    if (held_count < MAX_CLASSES_DEF) begin
      held_logits[held_count] = logit;
      if (logit > peak) peak = logit;
      held_count++;
    end else begin
      drop_seen = 1'b1;
    end
    if (!last) return;
    sum = '0;
    for (int i = 0; i < held_count; i++) begin
      d = int'(held_logits[i]) - int'(peak);
      if (d < int'(EXP_DIFF_MIN)) begin
        ex[i] = '0;
      end else begin
        idx = (int'(-d) * EXP_DEPTH_DEF) >> EXP_SHIFT;
        if (idx > EXP_DEPTH_DEF - 1) idx = EXP_DEPTH_DEF - 1;
        ex[i] = exp_lut[idx];
      end
      sum += ex[i];
    end
    best = 0;
    conf = '0;
    for (int i = 0; i < held_count; i++) begin
      p = (longint'(ex[i]) * 64'd65536 + longint'(sum / 2)) / longint'(sum);
      if (p > PROB_MAX) p = PROB_MAX;
      pr[i] = PROB_W'(p);
      if (i == 0 || pr[i] > conf) begin
        conf = pr[i];
        best = i;
      end
    end
    emit = (held_count < RESULT_LIMIT) ? held_count : RESULT_LIMIT;
    for (int i = 0; i < emit; i++) begin
      r.cls   = 4'(i);
      r.prob  = pr[i];
      r.pred  = 4'(best);
      r.conf  = conf;
      r.match = (best == int'(label));
      r.tag   = tag;
      r.ovf   = drop_seen;
      r.tail  = (i + 1 == emit);
      if (pin) begin
        r.pred  = pinned.pred;
        r.conf  = pinned.conf;
        r.match = pinned.match;
        r.ovf   = pinned.ovf;
      end
      prob_queue.push_back(r);
    end
    held_count = 0;
    peak       = LOGIT_MIN;
    drop_seen  = 1'b0;
  endtask

  task automatic offer_logit(input logic signed [LOGIT_W-1:0] logit, input logic last,
                             input logic [LABEL_W-1:0] label, input logic [TAG_W-1:0] tag,
                             input logic pin, input class_result_t pinned);
    in_chan.valid      <= 1'b1;
    in_chan.logit      <= logit;
    in_chan.last_logit <= last;
    in_chan.true_label <= label;
    in_chan.sample_tag <= tag;
    do @(posedge clk); while (in_chan.ready !== 1'b1);
    softmax_take_logit(logit, last, label, tag, pin, pinned);
  endtask

  task automatic sender_gap();
    int pick;
    int n;
    pick = $urandom_range(0, 99);
    if (calm || pick < 60) n = 0;
    else if (pick < 90) n = $urandom_range(1, 3);
    else if (pick < 98) n = $urandom_range(4, 12);
    else n = $urandom_range(30, 100);
    if (n > 0) begin
      in_chan.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic check_field(input string what, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
    end
  endtask

  initial begin : result_drain
    class_result_t want;
    class_result_t got;
    int            rx_idle;
    int            hold_left;
    int            pick;
    rx_idle   = 0;
    hold_left = 0;
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_chan.valid === 1'b1 && out_chan.ready === 1'b1) begin
        got = '{out_chan.class_index, out_chan.probability, out_chan.predicted_class,
                out_chan.confidence, out_chan.label_match, out_chan.tag_out,
                out_chan.overflow_flag, out_chan.last_result};
        if (prob_queue.size() == 0) begin
          mismatches++;
          $display("%0t: result with nothing pending: class %0d tag %h", $time,
                   got.cls, got.tag);
        end else begin
          want = prob_queue.pop_front();
          check_field("class_index", want.cls, got.cls);
          check_field("probability", want.prob, got.prob);
          check_field("predicted_class", want.pred, got.pred);
          check_field("confidence", want.conf, got.conf);
          check_field("label_match", want.match, got.match);
          check_field("tag_out", want.tag, got.tag);
          check_field("overflow_flag", want.ovf, got.ovf);
          check_field("last_result", want.tail, got.tail);
        end
      end
      if (stall_req) begin
        stall_req = 1'b0;
        hold_left = 600;
      end
      if (!rst_n || hold_left > 0 || rx_idle > 0) begin
        out_chan.ready <= 1'b0;
        if (hold_left > 0) hold_left--;
        else if (rx_idle > 0) rx_idle--;
      end else begin
        out_chan.ready <= 1'b1;
        if (!calm) begin
          pick = $urandom_range(0, 99);
          if (pick < 75) rx_idle = 0;
          else if (pick < 90) rx_idle = $urandom_range(1, 3);
          else if (pick < 98) rx_idle = $urandom_range(4, 12);
          else rx_idle = $urandom_range(30, 80);
        end
      end
    end
  end

  initial begin : stimulus
    longint unsigned           h;
    longint unsigned           term;
    longint unsigned           v;
    longint                    acc;
    class_result_t             pinned;
    class_result_t             no_pin;
    int                        random_sent;
    int                        sample_no;
    int                        len;
    int                        mode;
    int                        val;
    logic signed [LOGIT_W-1:0] base;
    logic signed [LOGIT_W-1:0] lv;

    // exp(-k/16) table, Q1.16, built from a truncated series for exp(-1/16)
    h    = (64'd16 << 32) / EXP_DEPTH_DEF;
    term = 64'd1 << 32;
    acc  = 64'sd1 << 32;
    for (int k = 1; k <= 12; k++) begin
      term = ((term * h) >> 32) / longint'(k);
      if (k % 2 == 1) acc -= longint'(term);
      else acc += longint'(term);
    end
    v = 64'd1 << 32;
    for (int i = 0; i < EXP_DEPTH_DEF; i++) begin
      exp_lut[i] = EXP_W'((v + 64'd32768) >> 16);
      v = (v * longint'(acc)) >> 32;
    end

    no_pin = '0;
    rst_n              <= 1'b0;
    in_chan.valid      <= 1'b0;
    in_chan.logit      <= '0;
    in_chan.last_logit <= 1'b0;
    in_chan.true_label <= '0;
    in_chan.sample_tag <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      pinned       = '0;
      pinned.pred  = directed_rows[i].pred;
      pinned.conf  = directed_rows[i].conf;
      pinned.match = directed_rows[i].match;
      pinned.ovf   = directed_rows[i].ovf;
      offer_logit(directed_rows[i].logit, directed_rows[i].last, directed_rows[i].label,
                  directed_rows[i].tag, directed_rows[i].pin, pinned);
      sender_gap();
    end
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (prob_queue.size() != 0);

    random_sent = 0;
    sample_no   = 0;
    while (random_sent < 330) begin
      // open with a sample that overflows the store, then one that fills it exactly
      if (sample_no == 0) len = 18;
      else if (sample_no == 1) len = MAX_CLASSES_DEF;
      else if ($urandom_range(0, 9) == 0) len = $urandom_range(16, 20);
      else len = $urandom_range(1, 6);
      mode = $urandom_range(0, 9);
      base = LOGIT_W'($urandom);
      for (int j = 0; j < len; j++) begin
        if (mode < 3) begin
          lv = LOGIT_W'($urandom);
        end else if (mode < 8) begin
          // cluster within +-16.0 so most classes keep a nonzero probability
          val = int'(base) + int'($urandom_range(0, 8191)) - 4096;
          if (val > 32767) val = 32767;
          if (val < -32768) val = -32768;
          lv = LOGIT_W'(val);
        end else begin
          lv = $urandom_range(0, 1) ? base : base - 16'sd512;
        end
        offer_logit(lv, j == len - 1, LABEL_W'($urandom), TAG_W'($urandom), 1'b0, no_pin);
        random_sent++;
        if (random_sent == 100) stall_req = 1'b1;
        calm = (random_sent >= 240 && random_sent < 290);
        if (sample_no == 30 && j == len - 1) begin
          in_chan.valid <= 1'b0;
          do @(posedge clk); while (prob_queue.size() != 0);
        end else begin
          sender_gap();
        end
      end
      sample_no++;
    end
    in_chan.valid <= 1'b0;

    while (prob_queue.size() != 0) @(posedge clk);
    repeat (500) @(posedge clk);
    if (mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/sac_pkg.sv
design/sac_if.sv
design/sac_ram.sv
design/sac_front.sv
design/sac_jobq.sv
design/sac_back.sv
design/softmax_argmax_classifier_head.sv
design/sac_chk.sv
tb/testbench.sv
